[rtl/ncs_pkg.sv]
// Shared types and constants for the nearest palette color search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ncs_pkg;

    // Field widths
    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 3 * CHAN_W;
    localparam int SQ_W    = 2 * CHAN_W;
    localparam int DIST_W  = 18;

    // Default palette depth
    localparam int PALETTE_SIZE_DEF = 256;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Input beat
    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } ncs_in_t;

    // Result beat
    typedef struct packed {
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
    } ncs_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic write;   // store the item color into the palette
        logic load;    // latch query color, restart scan
        logic read;    // read one palette entry, advance address
    } ncs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_addr;   // scan address is the final entry
        logic pipe_empty;  // no entry left in the distance pipeline
    } ncs_stat_t;

endpackage

`default_nettype wire

[rtl/ncs_datapath.sv]
// Datapath: palette memory, squared distance pipeline and best-so-far tracking.
// Depends on ncs_pkg; driven by ncs_ctrl through ncs_cmd_t / ncs_stat_t.
`default_nettype none

module ncs_datapath #(
    parameter int PALETTE_SIZE = ncs_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ncs_pkg::ncs_in_t  item,
    input  wire ncs_pkg::ncs_cmd_t cmd,
    output ncs_pkg::ncs_stat_t     stat,
    output ncs_pkg::ncs_out_t      result
);
    import ncs_pkg::*;

    localparam int ADDR_W = $clog2(PALETTE_SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_SIZE - 1);

    // Palette memory, undefined until written
    logic [COLOR_W-1:0] mem [PALETTE_SIZE];

    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] rdata_reg;
    logic               rd_vld_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;

    logic [CHAN_W-1:0]  q_red_reg;
    logic [CHAN_W-1:0]  q_green_reg;
    logic [CHAN_W-1:0]  q_blue_reg;

    logic [SQ_W-1:0]    sq_r_reg;
    logic [SQ_W-1:0]    sq_g_reg;
    logic [SQ_W-1:0]    sq_b_reg;
    logic               sq_vld_reg;
    logic [ADDR_W-1:0]  sq_idx_reg;

    logic               first_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    logic [ADDR_W-1:0]  best_idx_reg;

    logic               wr_in_range;
    logic [CHAN_W-1:0]  d_r;
    logic [CHAN_W-1:0]  d_g;
    logic [CHAN_W-1:0]  d_b;
    logic [DIST_W-1:0]  dist_sum;
    logic               take;

    // Writes beyond the palette are dropped
    assign wr_in_range = {1'b0, item.entry_index} < (IDX_W + 1)'(PALETTE_SIZE);

    // Memory write port and registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            mem[item.entry_index[ADDR_W-1:0]] <= {item.red, item.green, item.blue};
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    // Scan address and read valid tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            first_reg  <= 1'b1;
        end
        else
        begin
            rd_vld_reg <= cmd.read;
            sq_vld_reg <= rd_vld_reg;
            if (cmd.load)
            begin
                addr_reg <= '0;
            end
            else if (cmd.read)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                first_reg <= 1'b1;
            end
            else if (sq_vld_reg)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    // Query color and index tags
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_red_reg   <= item.red;
            q_green_reg <= item.green;
            q_blue_reg  <= item.blue;
        end
        rd_idx_reg <= addr_reg;
        sq_idx_reg <= rd_idx_reg;
    end

    // Per-channel absolute difference
    always_comb
    begin
        d_r = (rdata_reg[23:16] >= q_red_reg) ? rdata_reg[23:16] - q_red_reg
                                              : q_red_reg - rdata_reg[23:16];
        d_g = (rdata_reg[15:8] >= q_green_reg) ? rdata_reg[15:8] - q_green_reg
                                               : q_green_reg - rdata_reg[15:8];
        d_b = (rdata_reg[7:0] >= q_blue_reg) ? rdata_reg[7:0] - q_blue_reg
                                             : q_blue_reg - rdata_reg[7:0];
    end

    // Square stage
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(d_r) * SQ_W'(d_r);
        sq_g_reg <= SQ_W'(d_g) * SQ_W'(d_g);
        sq_b_reg <= SQ_W'(d_b) * SQ_W'(d_b);
    end

    // Sum and compare; strictly smaller wins so ties keep the lower index
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign take     = sq_vld_reg && (first_reg || (dist_sum < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg <= dist_sum;
            best_idx_reg  <= sq_idx_reg;
        end
    end

    assign stat.last_addr  = (addr_reg == LAST_ADDR);
    assign stat.pipe_empty = !rd_vld_reg && !sq_vld_reg;

    assign result.best_index    = IDX_W'(best_idx_reg);
    assign result.best_distance = best_dist_reg;

    // Square stage only ever follows a read beat
    a_sq_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld_reg |-> $past(rd_vld_reg))
        else $error("square stage valid without preceding read");

    // A new query never starts while entries are still in flight
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!rd_vld_reg && !sq_vld_reg))
        else $error("scan restarted with pipeline busy");

    // Address advances by one on every read that is not at the final entry
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.read && !cmd.load && !stat.last_addr) |=> (addr_reg == $past(addr_reg) + 1'b1))
        else $error("scan address did not advance");

endmodule

`default_nettype wire

[rtl/ncs_ctrl.sv]
// Controller state machine: accepts beats, sequences the palette scan, strobes done.
// Depends on ncs_pkg; commands ncs_datapath.
`default_nettype none

module ncs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               kind,
    input  wire ncs_pkg::ncs_stat_t stat,
    output ncs_pkg::ncs_cmd_t       cmd,
    output logic                    busy,
    output logic                    done
);
    import ncs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
                if (stat.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A query beat makes the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // A write beat leaves the block ready
    a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_WRITE) |=> !busy)
        else $error("write beat stalled the block");

endmodule

`default_nettype wire

[rtl/nearest_palette_color_search.sv]
// Top level of the nearest palette color search block.
// Depends on ncs_pkg, ncs_ctrl and ncs_datapath.
//
// A beat is taken when start is high and busy is low. A write beat (kind 0)
// stores its color at entry_index and leaves busy low, so writes can be
// issued every cycle; indexes at or above PALETTE_SIZE are dropped. A query
// beat (kind 1) scans every palette entry in index order, one memory read
// per cycle, through a three-stage read / square / compare pipeline; busy
// stays high through the scan and the pipeline drain, so no further beat is
// taken until the query has finished. The answer appears on result for
// exactly one cycle with done high, in the last busy cycle; there is no way
// to stall it, so it must be captured then. Every entry must be written after
// reset before the first query; unwritten entries read as garbage.
`default_nettype none

module nearest_palette_color_search #(
    parameter int PALETTE_SIZE = ncs_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire ncs_pkg::ncs_in_t item,
    output logic                  busy,
    output logic                  done,
    output ncs_pkg::ncs_out_t     result
);
    import ncs_pkg::*;

    ncs_cmd_t  cmd;
    ncs_stat_t stat;

    // Sequencer
    ncs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Palette and distance datapath
    ncs_datapath #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

[test/nearest_palette_color_search_test.sv]
// Self-checking bench for nearest_palette_color_search: palette loads and nearest-color
// queries, directed then random, each answer checked against a palette kept here.
// Depends on ncs_pkg and nearest_palette_color_search.

module nearest_palette_color_search_test;

    import ncs_pkg::*;

    localparam int          PALETTE       = PALETTE_SIZE_DEF;
    localparam int          RANDOM_ITEMS  = 1328;
    localparam int          CYCLE_LIMIT   = 4_000_000;
    localparam int          SETTLE_CYCLES = PALETTE + 8;
    localparam int unsigned NO_MATCH_DIST = 32'h7FFF_FFFF;

    // Mirror of the palette plus the queue of answers still owed by the block
    class nearest_color_tracker;
        logic [COLOR_W-1:0] palette_copy [PALETTE];
        ncs_out_t           answers_due [$];
        int                 mismatches;

        function new();
            mismatches = 0;
            foreach (palette_copy[i])
            begin
                palette_copy[i] = '0;
            end
        endfunction

        function int unsigned sq_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
            int unsigned d;
            d = (a >= b) ? int'(a - b) : int'(b - a);
            return d * d;
        endfunction

        // Full scan in index order; only a strictly smaller distance wins
        function ncs_out_t search_palette(ncs_in_t q);
            ncs_out_t          ans;
            int unsigned       best_sq;
            int unsigned       sq;
            logic [IDX_W-1:0]  best;
            logic [COLOR_W-1:0] c;
            best_sq = NO_MATCH_DIST;
            best    = '0;
            for (int i = 0; i < PALETTE; i++)
            begin
                c  = palette_copy[i];
                sq = sq_gap(c[23:16], q.red) + sq_gap(c[15:8], q.green) + sq_gap(c[7:0], q.blue);
                if (sq < best_sq)
                begin
                    best_sq = sq;
                    best    = IDX_W'(i);
                end
            end
            ans.best_index    = best;
            ans.best_distance = best_sq[DIST_W-1:0];
            return ans;
        endfunction

        // Accepted input beat: writes update the mirror, queries owe an answer
        function void take_item(ncs_in_t it);
            if (it.kind == KIND_WRITE)
            begin
                if (int'(it.entry_index) < PALETTE)
                    palette_copy[it.entry_index] = {it.red, it.green, it.blue};
            end
            else
            begin
                answers_due.push_back(search_palette(it));
            end
        endfunction

        // Result beat from the block, checked against the oldest owed answer
        function void compare_answer(ncs_out_t got);
            ncs_out_t want;
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: best_index %0d best_distance %0d",
                       got.best_index, got.best_distance);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            if (got.best_index !== want.best_index)
            begin
                $error("best_index: expected %0d, actual %0d", want.best_index, got.best_index);
                mismatches++;
            end
            if (got.best_distance !== want.best_distance)
            begin
                $error("best_distance: expected %0d, actual %0d",
                       want.best_distance, got.best_distance);
                mismatches++;
            end
        endfunction

        function int pending();
            return answers_due.size();
        endfunction
    endclass

    logic     clk   = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    ncs_in_t  item  = '0;
    logic     busy;
    logic     done;
    ncs_out_t result;
    int       cycles = 0;

    nearest_color_tracker tracker = new();

    nearest_palette_color_search #(
        .PALETTE_SIZE(PALETTE)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result beats last one cycle and cannot be stalled
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.compare_answer(result);
    end

    function automatic ncs_in_t make_beat(logic k, int idx, logic [COLOR_W-1:0] color);
        ncs_in_t b;
        b.kind        = k;
        b.entry_index = IDX_W'(idx);
        {b.red, b.green, b.blue} = color;
        return b;
    endfunction

    // Channel biased toward the ends and the midpoint of the range
    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // Mostly writes; colors random, extreme, or copied from the palette to force ties
    function automatic ncs_in_t random_beat();
        ncs_in_t            b;
        logic [COLOR_W-1:0] c;
        int                 mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            c = COLOR_W'($urandom);
        else if (mode < 8)
            c = {pick_channel(), pick_channel(), pick_channel()};
        else
            c = tracker.palette_copy[$urandom_range(0, PALETTE - 1)];
        b = make_beat(($urandom_range(0, 99) < 72) ? KIND_WRITE : KIND_QUERY,
                      $urandom_range(0, 255), c);
        return b;
    endfunction

    // Hold the beat until the block takes it
    task automatic send_beat(input ncs_in_t beat);
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        tracker.take_item(beat);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every owed answer has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    initial
    begin
        int gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Whole palette written black, back to back, before any query
        for (int i = 0; i < PALETTE; i++)
            send_beat(make_beat(KIND_WRITE, i, 24'h000000));

        // Directed: distance extremes, ties, index field ignored on queries
        send_beat(make_beat(KIND_QUERY, 8'h00, 24'hFFFFFF));
        send_beat(make_beat(KIND_QUERY, 8'hFF, 24'h000000));
        send_beat(make_beat(KIND_WRITE, 255,   24'hFFFFFF));
        send_beat(make_beat(KIND_QUERY, 8'h5A, 24'hFFFFFF));
        send_beat(make_beat(KIND_WRITE, 0,     24'hFFFFFF));
        send_beat(make_beat(KIND_QUERY, 8'hA5, 24'hFFFFFF));
        send_beat(make_beat(KIND_QUERY, 8'h00, 24'h000000));
        send_beat(make_beat(KIND_WRITE, 1,     24'hFF0000));
        send_beat(make_beat(KIND_WRITE, 2,     24'h00FF00));
        send_beat(make_beat(KIND_WRITE, 3,     24'h0000FF));
        send_beat(make_beat(KIND_WRITE, 128,   24'h7F7F7F));
        send_beat(make_beat(KIND_QUERY, 8'h01, 24'hFF0000));
        send_beat(make_beat(KIND_QUERY, 8'h02, 24'h00FF00));
        send_beat(make_beat(KIND_QUERY, 8'h03, 24'h0000FF));
        send_beat(make_beat(KIND_QUERY, 8'hFF, 24'h808080));
        send_beat(make_beat(KIND_QUERY, 8'h80, 24'h7F7F80));
        drain();

        // Random beats; one stretch with no idling, one full drain midway
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            send_beat(random_beat());
            if (n == RANDOM_ITEMS / 2)
                drain();
            else if (!(n >= 500 && n < 900) && $urandom_range(0, 99) < 23)
            begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PALETTE + 8)
                                                  : $urandom_range(1, 4);
                idle_cycles(gap);
            end
        end
        start <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
